// File: hdl/ssd_pkg.sv
package ssd_pkg;

  localparam logic [7:0] HDR_BYTE = 8'd19;

  typedef enum logic [2:0] {
    FN_BYTE  = 3'd0,
    FN_POP   = 3'd1,
    FN_START = 3'd2,
    FN_ABORT = 3'd3,
    FN_RDERR = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LIST   = 2'd1,
    MODE_STREAM = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SIZE   = 3'd1,
    PH_ID     = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_FULL      = 4'd1;
  localparam logic [3:0] ERR_UNEXP     = 4'd2;
  localparam logic [3:0] ERR_NOHDR     = 4'd3;
  localparam logic [3:0] ERR_IDMIS     = 4'd4;
  localparam logic [3:0] ERR_CHECKSUM  = 4'd5;
  localparam logic [3:0] ERR_FULLSTRM  = 4'd6;
  localparam logic [3:0] ERR_EMPTY     = 4'd7;
  localparam logic [3:0] ERR_ABORTED   = 4'd8;

  localparam logic [2:0] REG_FRAMED = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_IDS_A  = 3'd2;
  localparam logic [2:0] REG_IDS_B  = 3'd3;
  localparam logic [2:0] REG_IDS_C  = 3'd4;
  localparam logic [2:0] REG_IDS_D  = 3'd5;
  localparam logic [2:0] REG_WIDE_L = 3'd6;
  localparam logic [2:0] REG_WIDE_H = 3'd7;

  typedef struct packed {
    logic        framed;
    logic [5:0]  count;
    logic [255:0] ids;
    logic [127:0] wide;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] data;
    logic [1:0]  size;
  } rec_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic        send_pause;
    logic        record_valid;
    logic [7:0]  record_id;
    logic [15:0] record_data;
    logic [1:0]  record_size;
    logic [3:0]  latched_error;
    logic        busy_res;
  } res_t;

endpackage

// File: hdl/sensor_stream_deframer.sv
// A result appears in the cycle after its word is accepted.
// Throughput: one word per cycle while in_ready is high; a single pass through the core's next-state logic.
// in_ready drops only while the result register holds a word not yet taken.
// Reset (rst, synchronous): control state and config registers to defaults; result data
// registers and FIFO contents stay undefined until written (the FIFO is tracked by the pointers alone).
module sensor_stream_deframer #(
  parameter int FIFO_DEPTH    = 64,
  parameter int LIST_LEN      = 32,
  parameter int IGNORE_FRAMES = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  error_code,
  output logic        send_pause,
  output logic        record_valid,
  output logic [7:0]  record_id,
  output logic [15:0] record_data,
  output logic [1:0]  record_size,
  output logic [3:0]  latched_error,
  output logic        busy_res
);

  ssd_pkg::cfg_t cfg;
  ssd_pkg::res_t res;
  logic          go;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign go       = in_valid && in_ready;

  ssd_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  ssd_core #(
    .FIFO_DEPTH(FIFO_DEPTH), .LIST_LEN(LIST_LEN), .IGNORE_FRAMES(IGNORE_FRAMES)
  ) u_core (
    .clk, .rst, .cfg, .go, .func, .rx_byte, .res
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign error_code    = res.error_code;
  assign send_pause    = res.send_pause;
  assign record_valid  = res.record_valid;
  assign record_id     = res.record_id;
  assign record_data   = res.record_data;
  assign record_size   = res.record_size;
  assign latched_error = res.latched_error;
  assign busy_res      = res.busy_res;

endmodule

// File: hdl/ssd_regs.sv
module ssd_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [5:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output ssd_pkg::cfg_t    cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[5:3];
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.framed <= 1'b0;
      cfg.count  <= 6'd1;
      cfg.ids    <= '0;
      cfg.wide   <= '0;
    end else if (wr) begin
      unique case (idx)
        ssd_pkg::REG_FRAMED: cfg.framed <= pwdata[0];
        ssd_pkg::REG_COUNT:  cfg.count <= pwdata[5:0];
        ssd_pkg::REG_IDS_A:  cfg.ids[63:0] <= pwdata;
        ssd_pkg::REG_IDS_B:  cfg.ids[127:64] <= pwdata;
        ssd_pkg::REG_IDS_C:  cfg.ids[191:128] <= pwdata;
        ssd_pkg::REG_IDS_D:  cfg.ids[255:192] <= pwdata;
        ssd_pkg::REG_WIDE_L: cfg.wide[63:0] <= pwdata;
        ssd_pkg::REG_WIDE_H: cfg.wide[127:64] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ssd_pkg::REG_FRAMED: prdata = {63'd0, cfg.framed};
      ssd_pkg::REG_COUNT:  prdata = {58'd0, cfg.count};
      ssd_pkg::REG_IDS_A:  prdata = cfg.ids[63:0];
      ssd_pkg::REG_IDS_B:  prdata = cfg.ids[127:64];
      ssd_pkg::REG_IDS_C:  prdata = cfg.ids[191:128];
      ssd_pkg::REG_IDS_D:  prdata = cfg.ids[255:192];
      ssd_pkg::REG_WIDE_L: prdata = cfg.wide[63:0];
      ssd_pkg::REG_WIDE_H: prdata = cfg.wide[127:64];
      default:             prdata = '0;
    endcase
  end

endmodule

// File: hdl/ssd_core.sv
module ssd_core #(
  parameter int FIFO_DEPTH    = 64,
  parameter int LIST_LEN      = 32,
  parameter int IGNORE_FRAMES = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  ssd_pkg::cfg_t    cfg,
  input  logic             go,
  input  logic [2:0]       func,
  input  logic [7:0]       rx_byte,
  output ssd_pkg::res_t    res
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  ssd_pkg::rec_t store [FIFO_DEPTH];

  logic [PW-1:0]  read_ptr, commit_ptr, pending_ptr;
  logic [PW-1:0]  read_ptr_next, commit_ptr_next, pending_ptr_next;
  ssd_pkg::mode_t  mode, mode_next;
  ssd_pkg::phase_t phase, phase_next;
  logic [5:0] list_index, list_index_next;
  logic       byte_index, byte_index_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] length_count, length_count_next;
  logic       ignoring, ignoring_next;
  logic [3:0] ignore_count, ignore_count_next;
  logic       sync_win, sync_win_next;
  logic [3:0] first_error, first_error_next;

  // the entry under construction lives in a working register, not the store
  ssd_pkg::rec_t work, work_next;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  ssd_pkg::res_t res_next;

  logic [5:0] lcount;
  logic [5:0] lidx_inc;
  logic [PW-1:0] cp_inc, pp_inc;
  logic [7:0] prep_id;
  logic [5:0] prep_idx;
  ssd_pkg::rec_t prep_rec;
  ssd_pkg::rec_t added;
  logic          done;
  logic [7:0]    c;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (32'(p) + 1 >= FIFO_DEPTH) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [1:0] idsz(input logic [7:0] id, input logic [127:0] wide);
    idsz = (!id[7] && wide[id[6:0]]) ? 2'd2 : 2'd1;
  endfunction

  always_comb begin
    if (cfg.count == 6'd0) lcount = 6'd1;
    else if (32'(cfg.count) > LIST_LEN) lcount = 6'(LIST_LEN);
    else lcount = cfg.count;
  end

  assign c        = rx_byte;
  assign cp_inc   = nxt(commit_ptr);
  assign pp_inc   = nxt(pending_ptr);
  assign lidx_inc = list_index + 6'd1;

  always_comb begin
    prep_id        = cfg.ids[{prep_idx[4:0], 3'b000} +: 8];
    prep_rec.id    = prep_id;
    prep_rec.size  = idsz(prep_id, cfg.wide);
    prep_rec.data  = '0;
  end

  always_comb begin
    added = work;
    if (work.size == 2'd2 && !byte_index) added.data = work.data | {c, 8'd0};
    else added.data = work.data | {8'd0, c};
    done = ({1'b0, byte_index} + 2'd1) >= work.size;
  end

  always_comb begin
    logic full_c;
    logic [3:0] fe;
    read_ptr_next     = read_ptr;
    commit_ptr_next   = commit_ptr;
    pending_ptr_next  = pending_ptr;
    mode_next         = mode;
    phase_next        = phase;
    list_index_next   = list_index;
    byte_index_next   = byte_index;
    running_sum_next  = running_sum;
    frame_length_next = frame_length;
    length_count_next = length_count;
    ignoring_next     = ignoring;
    ignore_count_next = ignore_count;
    sync_win_next     = sync_win;
    first_error_next  = first_error;
    work_next         = work;
    wr_en             = 1'b0;
    wr_addr           = pending_ptr;
    prep_idx          = lidx_inc;
    res_next          = '0;
    full_c            = (read_ptr == cp_inc);
    fe                = first_error;

    unique case (func)
      ssd_pkg::FN_BYTE: begin
        if (full_c) begin
          if (fe == 4'd0) fe = ssd_pkg::ERR_FULL;
          res_next.error_code = fe;
        end else if (mode == ssd_pkg::MODE_IDLE) begin
          res_next.send_pause = 1'b1;
          if (fe == 4'd0) fe = ssd_pkg::ERR_UNEXP;
          res_next.error_code = fe;
        end else if (mode == ssd_pkg::MODE_STREAM) begin
          running_sum_next  = running_sum + c;
          length_count_next = length_count + 8'd1;
          unique case (phase)
            ssd_pkg::PH_HEADER: begin
              running_sum_next  = ssd_pkg::HDR_BYTE;
              frame_length_next = '0;
              length_count_next = '0;
              if (c != ssd_pkg::HDR_BYTE) begin
                if (!ignoring) begin
                  if (fe == 4'd0) fe = ssd_pkg::ERR_NOHDR;
                  res_next.error_code = fe;
                end
              end else if (ignoring && 32'(ignore_count) < IGNORE_FRAMES) begin
                ignore_count_next = ignore_count + 4'd1;
              end else begin
                // full is already excluded above, so a frame starts
                if (ignoring) begin
                  ignore_count_next = '0;
                  ignoring_next     = 1'b0;
                  sync_win_next     = 1'b1;
                end
                phase_next       = ssd_pkg::PH_SIZE;
                pending_ptr_next = commit_ptr;
                list_index_next  = '0;
                prep_idx         = '0;
                work_next        = prep_rec;
              end
            end
            ssd_pkg::PH_SIZE: begin
              frame_length_next = c;
              length_count_next = '0;
              phase_next        = ssd_pkg::PH_ID;
            end
            ssd_pkg::PH_ID: begin
              if (c == work.id) begin
                phase_next = ssd_pkg::PH_DATA;
              end else begin
                phase_next = ssd_pkg::PH_HEADER;
                if (!sync_win) begin
                  if (fe == 4'd0) fe = ssd_pkg::ERR_IDMIS;
                  res_next.error_code = fe;
                end
              end
            end
            ssd_pkg::PH_DATA: begin
              work_next       = added;
              byte_index_next = !done;
              if (done) begin
                wr_en            = 1'b1;
                wr_addr          = pending_ptr;
                list_index_next  = lidx_inc;
                pending_ptr_next = pp_inc;
                if (read_ptr == nxt(pp_inc)) begin
                  ignoring_next = 1'b1;
                  phase_next    = ssd_pkg::PH_HEADER;
                end else if (lidx_inc < lcount) begin
                  work_next  = prep_rec;
                  phase_next = ssd_pkg::PH_ID;
                end else begin
                  phase_next = ssd_pkg::PH_CHECK;
                end
              end
            end
            default: begin
              phase_next = ssd_pkg::PH_HEADER;
              if (running_sum_next == 8'd0 && frame_length == length_count) begin
                sync_win_next   = 1'b0;
                commit_ptr_next = pending_ptr;
              end else if (!sync_win) begin
                if (fe == 4'd0) fe = ssd_pkg::ERR_CHECKSUM;
                res_next.error_code = fe;
              end
            end
          endcase
        end else begin
          work_next       = added;
          byte_index_next = !done;
          if (done) begin
            wr_en           = 1'b1;
            wr_addr         = commit_ptr;
            commit_ptr_next = cp_inc;
            list_index_next = lidx_inc;
            if (lidx_inc < lcount) work_next = prep_rec;
            else mode_next = ssd_pkg::MODE_IDLE;
          end
        end
      end
      ssd_pkg::FN_POP: begin
        if (read_ptr == commit_ptr) begin
          res_next.error_code = ssd_pkg::ERR_EMPTY;
        end else begin
          res_next.record_valid = 1'b1;
          read_ptr_next = nxt(read_ptr);
        end
      end
      ssd_pkg::FN_START: begin
        if (cfg.framed) begin
          if (mode == ssd_pkg::MODE_STREAM) res_next.send_pause = 1'b1;
          mode_next  = ssd_pkg::MODE_STREAM;
          phase_next = ssd_pkg::PH_HEADER;
        end else begin
          mode_next = ssd_pkg::MODE_LIST;
        end
        list_index_next = '0;
        byte_index_next = 1'b0;
        prep_idx        = '0;
        work_next       = prep_rec;
      end
      ssd_pkg::FN_ABORT: begin
        if (mode == ssd_pkg::MODE_STREAM) res_next.send_pause = 1'b1;
        if (mode != ssd_pkg::MODE_IDLE) begin
          mode_next = ssd_pkg::MODE_IDLE;
          if (fe == 4'd0) fe = ssd_pkg::ERR_ABORTED;
        end
      end
      ssd_pkg::FN_RDERR: begin
        res_next.latched_error = first_error;
        fe = '0;
      end
      default: ;
    endcase
    first_error_next = fe;
    res_next.busy_res = (mode_next != ssd_pkg::MODE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr     <= '0;
      commit_ptr   <= '0;
      pending_ptr  <= '0;
      mode         <= ssd_pkg::MODE_IDLE;
      phase        <= ssd_pkg::PH_HEADER;
      list_index   <= '0;
      byte_index   <= 1'b0;
      running_sum  <= '0;
      frame_length <= '0;
      length_count <= '0;
      ignoring     <= 1'b0;
      ignore_count <= '0;
      sync_win     <= 1'b1;
      first_error  <= '0;
      work         <= '0;
    end else if (go) begin
      read_ptr     <= read_ptr_next;
      commit_ptr   <= commit_ptr_next;
      pending_ptr  <= pending_ptr_next;
      mode         <= mode_next;
      phase        <= phase_next;
      list_index   <= list_index_next;
      byte_index   <= byte_index_next;
      running_sum  <= running_sum_next;
      frame_length <= frame_length_next;
      length_count <= length_count_next;
      ignoring     <= ignoring_next;
      ignore_count <= ignore_count_next;
      sync_win     <= sync_win_next;
      first_error  <= first_error_next;
      work         <= work_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && wr_en) store[wr_addr] <= added;
  end

  ssd_pkg::rec_t rd_q;
  ssd_pkg::res_t res_q;

  always_ff @(posedge clk) begin
    if (go) begin
      rd_q  <= store[read_ptr];
      res_q <= res_next;
    end
  end

  always_comb begin
    res = res_q;
    if (res_q.record_valid) begin
      res.record_id   = rd_q.id;
      res.record_data = rd_q.data;
      res.record_size = rd_q.size;
    end
  end

endmodule

// File: hdl/ssd_checker.sv
module ssd_assert (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        record_valid,
  input logic [1:0]  record_size,
  input logic [3:0]  error_code,
  input logic [3:0]  latched_error
);

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("ready low with empty output");

  a_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid) else $error("word produced no result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");

  a_rec: assert property (@(posedge clk) disable iff (rst)
    (out_valid && record_valid) |->
      (error_code == ssd_pkg::ERR_NONE && record_size != 2'd0))
    else $error("bad popped record");

  a_lerr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && latched_error != ssd_pkg::ERR_NONE) |-> !record_valid)
    else $error("record with error read");

endmodule

bind sensor_stream_deframer ssd_assert u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .record_valid,
  .record_size, .error_code, .latched_error
);

// File: tb/sv/ssd_checker.sv
module ssd_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  error_code,
  input  logic        send_pause,
  input  logic        record_valid,
  input  logic [7:0]  record_id,
  input  logic [15:0] record_data,
  input  logic [1:0]  record_size,
  input  logic [3:0]  latched_error,
  input  logic        busy_res,
  output int          fails,
  output int          pending
);

  localparam int LIST_MAX  = 32;
  localparam int SKIP_HDRS = 2;

  logic         cfg_framed;
  logic [5:0]   cfg_count;
  logic [255:0] cfg_ids;
  logic [127:0] cfg_wide;

  ssd_pkg::rec_t   store [64];
  logic [5:0]      rd_ptr, cm_ptr, pd_ptr, lidx;
  ssd_pkg::mode_t  mode;
  ssd_pkg::phase_t phase;
  logic            bidx, skipping, sync_win;
  logic [7:0]      sum, flen, lcnt;
  logic [3:0]      skip_cnt, first_err;

  ssd_pkg::res_t   result_q [$];
  ssd_pkg::res_t   got, want;

  initial begin
    fails = 0;
    pending = 0;
  end

  function automatic logic [5:0] wrap_inc(logic [5:0] p);
    return p + 6'd1;
  endfunction

  function automatic logic is_full(logic [5:0] head, logic [5:0] tail);
    return head == wrap_inc(tail);
  endfunction

  function automatic int list_len();
    int n;
    n = int'(cfg_count);
    if (n == 0) n = 1;
    if (n > LIST_MAX) n = LIST_MAX;
    return n;
  endfunction

  function automatic logic [1:0] width_of(logic [7:0] id);
    if (id < 8'd128 && cfg_wide[id[6:0]]) return 2'd2;
    return 2'd1;
  endfunction

  function automatic void load_entry(logic [5:0] slot, logic [5:0] idx);
    logic [7:0] id;
    id = cfg_ids[idx[4:0]*8 +: 8];
    store[slot].id = id;
    store[slot].size = width_of(id);
    store[slot].data = 16'd0;
  endfunction

  function automatic logic [3:0] latch_err(logic [3:0] e);
    if (first_err == ssd_pkg::ERR_NONE) first_err = e;
    return first_err;
  endfunction

  function automatic logic add_data(logic [5:0] slot, logic [7:0] c);
    logic [15:0] v;
    v = (store[slot].size == 2'd2 && !bidx) ? {c, 8'd0} : {8'd0, c};
    store[slot].data = store[slot].data | v;
    if (int'(bidx) + 1 >= int'(store[slot].size)) begin
      bidx = 1'b0;
      return 1'b1;
    end
    bidx = 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [3:0] frame_byte(logic [7:0] c);
    sum = sum + c;
    lcnt = lcnt + 8'd1;
    case (phase)
      ssd_pkg::PH_HEADER: begin
        sum = ssd_pkg::HDR_BYTE;
        flen = 8'd0;
        lcnt = 8'd0;
        if (c != ssd_pkg::HDR_BYTE)
          return skipping ? ssd_pkg::ERR_NONE : latch_err(ssd_pkg::ERR_NOHDR);
        if (skipping) begin
          if (skip_cnt < SKIP_HDRS) begin
            skip_cnt = skip_cnt + 4'd1;
            return ssd_pkg::ERR_NONE;
          end
          skip_cnt = 4'd0;
          skipping = 1'b0;
          sync_win = 1'b1;
          if (is_full(rd_ptr, cm_ptr)) begin
            skipping = 1'b1;
            return latch_err(ssd_pkg::ERR_FULLSTRM);
          end
        end
        if (is_full(rd_ptr, cm_ptr)) begin
          skipping = 1'b1;
          return ssd_pkg::ERR_NONE;
        end
        phase = ssd_pkg::PH_SIZE;
        pd_ptr = cm_ptr;
        lidx = 6'd0;
        load_entry(pd_ptr, 6'd0);
        return ssd_pkg::ERR_NONE;
      end
      ssd_pkg::PH_SIZE: begin
        flen = c;
        lcnt = 8'd0;
        phase = ssd_pkg::PH_ID;
        return ssd_pkg::ERR_NONE;
      end
      ssd_pkg::PH_ID: begin
        if (c == store[pd_ptr].id) begin
          phase = ssd_pkg::PH_DATA;
          return ssd_pkg::ERR_NONE;
        end
        phase = ssd_pkg::PH_HEADER;
        return sync_win ? ssd_pkg::ERR_NONE : latch_err(ssd_pkg::ERR_IDMIS);
      end
      ssd_pkg::PH_DATA: begin
        if (add_data(pd_ptr, c)) begin
          lidx = lidx + 6'd1;
          pd_ptr = wrap_inc(pd_ptr);
          if (is_full(rd_ptr, pd_ptr)) begin
            skipping = 1'b1;
            phase = ssd_pkg::PH_HEADER;
            return ssd_pkg::ERR_NONE;
          end
          if (int'(lidx) < list_len()) begin
            load_entry(pd_ptr, lidx);
            phase = ssd_pkg::PH_ID;
          end else begin
            phase = ssd_pkg::PH_CHECK;
          end
        end
        return ssd_pkg::ERR_NONE;
      end
      default: begin
        phase = ssd_pkg::PH_HEADER;
        if (sum == 8'd0 && flen == lcnt - 8'd1) begin
          sync_win = 1'b0;
          cm_ptr = pd_ptr;
          return ssd_pkg::ERR_NONE;
        end
        return sync_win ? ssd_pkg::ERR_NONE : latch_err(ssd_pkg::ERR_CHECKSUM);
      end
    endcase
  endfunction

  function automatic ssd_pkg::res_t predict(logic [2:0] f, logic [7:0] c);
    ssd_pkg::res_t r;
    r = '0;
    case (f)
      ssd_pkg::FN_BYTE: begin
        if (is_full(rd_ptr, cm_ptr)) begin
          r.error_code = latch_err(ssd_pkg::ERR_FULL);
        end else if (mode == ssd_pkg::MODE_IDLE) begin
          r.send_pause = 1'b1;
          r.error_code = latch_err(ssd_pkg::ERR_UNEXP);
        end else if (mode == ssd_pkg::MODE_STREAM) begin
          r.error_code = frame_byte(c);
        end else if (add_data(cm_ptr, c)) begin
          cm_ptr = wrap_inc(cm_ptr);
          lidx = lidx + 6'd1;
          if (int'(lidx) < list_len()) load_entry(cm_ptr, lidx);
          else mode = ssd_pkg::MODE_IDLE;
        end
      end
      ssd_pkg::FN_POP: begin
        if (rd_ptr == cm_ptr) begin
          r.error_code = ssd_pkg::ERR_EMPTY;
        end else begin
          r.record_valid = 1'b1;
          r.record_id = store[rd_ptr].id;
          r.record_data = store[rd_ptr].data;
          r.record_size = store[rd_ptr].size;
          rd_ptr = wrap_inc(rd_ptr);
        end
      end
      ssd_pkg::FN_START: begin
        if (cfg_framed) begin
          if (mode == ssd_pkg::MODE_STREAM) r.send_pause = 1'b1;
          mode = ssd_pkg::MODE_STREAM;
          phase = ssd_pkg::PH_HEADER;
        end else begin
          mode = ssd_pkg::MODE_LIST;
        end
        lidx = 6'd0;
        bidx = 1'b0;
        load_entry(cm_ptr, 6'd0);
      end
      ssd_pkg::FN_ABORT: begin
        if (mode == ssd_pkg::MODE_STREAM) r.send_pause = 1'b1;
        if (mode != ssd_pkg::MODE_IDLE) begin
          mode = ssd_pkg::MODE_IDLE;
          void'(latch_err(ssd_pkg::ERR_ABORTED));
        end
      end
      ssd_pkg::FN_RDERR: begin
        r.latched_error = first_err;
        first_err = ssd_pkg::ERR_NONE;
      end
      default: ;
    endcase
    r.busy_res = (mode != ssd_pkg::MODE_IDLE);
    return r;
  endfunction

  task report(string what, logic [31:0] seen, logic [31:0] wanted);
    $display("mismatch %s: got %0h expected %0h", what, seen, wanted);
    fails++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_framed = 1'b0;
      cfg_count = 6'd1;
      cfg_ids = '0;
      cfg_wide = '0;
      rd_ptr = '0;
      cm_ptr = '0;
      pd_ptr = '0;
      lidx = '0;
      mode = ssd_pkg::MODE_IDLE;
      phase = ssd_pkg::PH_HEADER;
      bidx = 1'b0;
      skipping = 1'b0;
      sync_win = 1'b1;
      sum = '0;
      flen = '0;
      lcnt = '0;
      skip_cnt = '0;
      first_err = ssd_pkg::ERR_NONE;
      result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{error_code, send_pause, record_valid, record_id, record_data,
                record_size, latched_error, busy_res};
        if (result_q.size() == 0) begin
          report("unexpected word", 32'(got), 32'd0);
        end else begin
          want = result_q.pop_front();
          if (got.error_code !== want.error_code)
            report("error_code", 32'(got.error_code), 32'(want.error_code));
          if (got.send_pause !== want.send_pause)
            report("send_pause", 32'(got.send_pause), 32'(want.send_pause));
          if (got.record_valid !== want.record_valid)
            report("record_valid", 32'(got.record_valid), 32'(want.record_valid));
          if (got.record_id !== want.record_id)
            report("record_id", 32'(got.record_id), 32'(want.record_id));
          if (got.record_data !== want.record_data)
            report("record_data", 32'(got.record_data), 32'(want.record_data));
          if (got.record_size !== want.record_size)
            report("record_size", 32'(got.record_size), 32'(want.record_size));
          if (got.latched_error !== want.latched_error)
            report("latched_error", 32'(got.latched_error), 32'(want.latched_error));
          if (got.busy_res !== want.busy_res)
            report("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        end
      end
      if (in_valid && in_ready) result_q.push_back(predict(func, rx_byte));
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          ssd_pkg::REG_FRAMED: cfg_framed = pwdata[0];
          ssd_pkg::REG_COUNT:  cfg_count = pwdata[5:0];
          ssd_pkg::REG_IDS_A:  cfg_ids[63:0] = pwdata;
          ssd_pkg::REG_IDS_B:  cfg_ids[127:64] = pwdata;
          ssd_pkg::REG_IDS_C:  cfg_ids[191:128] = pwdata;
          ssd_pkg::REG_IDS_D:  cfg_ids[255:192] = pwdata;
          ssd_pkg::REG_WIDE_L: cfg_wide[63:0] = pwdata;
          ssd_pkg::REG_WIDE_H: cfg_wide[127:64] = pwdata;
          default: ;
        endcase
      end
    end
    pending = result_q.size();
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = ssd_pkg::FN_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  error_code;
  logic        send_pause;
  logic        record_valid;
  logic [7:0]  record_id;
  logic [15:0] record_data;
  logic [1:0]  record_size;
  logic [3:0]  latched_error;
  logic        busy_res;
  int          fails;
  int          pending;

  logic         took = 1'b0;
  logic         calm = 1'b0;
  int           sent = 0;
  logic [5:0]   t_count = 6'd1;
  logic [255:0] t_ids = '0;
  logic [127:0] t_wide = '0;

  sensor_stream_deframer u_dut (.*);
  ssd_checker u_chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) took <= in_valid && in_ready;

  always @(negedge clk) out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 16);

  task automatic put_word(logic [2:0] f, logic [7:0] b);
    int n;
    if (!calm && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(negedge clk);
    end
    in_valid = 1'b1;
    func = f;
    rx_byte = b;
    do begin
      @(posedge clk);
      #1;
    end while (!took);
    @(negedge clk);
    sent++;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 3'b000};
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    case (idx)
      ssd_pkg::REG_COUNT:  t_count = v[5:0];
      ssd_pkg::REG_IDS_A:  t_ids[63:0] = v;
      ssd_pkg::REG_IDS_B:  t_ids[127:64] = v;
      ssd_pkg::REG_IDS_C:  t_ids[191:128] = v;
      ssd_pkg::REG_IDS_D:  t_ids[255:192] = v;
      ssd_pkg::REG_WIDE_L: t_wide[63:0] = v;
      ssd_pkg::REG_WIDE_H: t_wide[127:64] = v;
      default: ;
    endcase
  endtask

  task automatic setup(logic framed, logic [5:0] cnt, logic [255:0] ids, logic [127:0] wide);
    settle();
    write_reg(ssd_pkg::REG_FRAMED, {63'd0, framed});
    write_reg(ssd_pkg::REG_COUNT, {58'd0, cnt});
    write_reg(ssd_pkg::REG_IDS_A, ids[63:0]);
    write_reg(ssd_pkg::REG_IDS_B, ids[127:64]);
    write_reg(ssd_pkg::REG_IDS_C, ids[191:128]);
    write_reg(ssd_pkg::REG_IDS_D, ids[255:192]);
    write_reg(ssd_pkg::REG_WIDE_L, wide[63:0]);
    write_reg(ssd_pkg::REG_WIDE_H, wide[127:64]);
  endtask

  function automatic int list_len();
    int n;
    n = int'(t_count);
    if (n == 0) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  function automatic int width_of(logic [7:0] id);
    return (id < 8'd128 && t_wide[id[6:0]]) ? 2 : 1;
  endfunction

  // send the data bytes of one list response
  task automatic send_list();
    logic [7:0] id;
    for (int i = 0; i < list_len(); i++) begin
      id = t_ids[i*8 +: 8];
      repeat (width_of(id)) put_word(ssd_pkg::FN_BYTE, 8'($urandom));
    end
  endtask

  // build and send a frame for the current id list, optionally broken
  task automatic send_frame(logic good);
    logic [7:0] body [$];
    logic [7:0] id, size, total, cks;
    int k;
    for (int i = 0; i < list_len(); i++) begin
      id = t_ids[i*8 +: 8];
      body.push_back(id);
      repeat (width_of(id)) body.push_back(8'($urandom));
    end
    size = 8'(body.size());
    total = ssd_pkg::HDR_BYTE + size;
    foreach (body[i]) total = total + body[i];
    cks = -total;
    if (!good) begin
      k = $urandom_range(2);
      if (k == 0) cks = cks ^ 8'($urandom_range(1, 255));
      else if (k == 1) size = size + 8'($urandom_range(1, 3));
      else begin
        k = $urandom_range(body.size() - 1);
        body[k] = body[k] ^ 8'($urandom_range(1, 255));
      end
    end
    put_word(ssd_pkg::FN_BYTE, ssd_pkg::HDR_BYTE);
    put_word(ssd_pkg::FN_BYTE, size);
    foreach (body[i]) put_word(ssd_pkg::FN_BYTE, body[i]);
    put_word(ssd_pkg::FN_BYTE, cks);
  endtask

  task automatic run_phase(logic framed, int target);
    int r, stop;
    stop = sent + target;
    put_word(ssd_pkg::FN_START, 8'($urandom));
    while (sent < stop) begin
      r = $urandom_range(99);
      if (r < 60) begin
        if (framed) send_frame($urandom_range(9) < 7);
        else begin
          send_list();
          put_word(ssd_pkg::FN_START, 8'($urandom));
        end
      end else if (r < 82) begin
        repeat ($urandom_range(1, 16)) put_word(ssd_pkg::FN_POP, 8'($urandom));
      end else if (r < 88) put_word(ssd_pkg::FN_BYTE, 8'($urandom));
      else if (r < 92) put_word(ssd_pkg::FN_RDERR, 8'($urandom));
      else if (r < 95) put_word(ssd_pkg::FN_START, 8'($urandom));
      else if (r < 98) begin
        put_word(ssd_pkg::FN_ABORT, 8'($urandom));
        put_word(ssd_pkg::FN_START, 8'($urandom));
      end else put_word(3'($urandom_range(5, 7)), 8'($urandom));
    end
    put_word(ssd_pkg::FN_ABORT, 8'($urandom));
  endtask

  logic [255:0] rnd_ids;
  logic [127:0] rnd_wide;

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    put_word(ssd_pkg::FN_BYTE, 8'h00);
    put_word(ssd_pkg::FN_POP, 8'h00);
    put_word(ssd_pkg::FN_RDERR, 8'h00);
    put_word(ssd_pkg::FN_START, 8'h00);
    put_word(ssd_pkg::FN_BYTE, 8'hFF);
    put_word(ssd_pkg::FN_POP, 8'h00);
    put_word(3'd5, 8'hFF);
    put_word(3'd6, 8'h00);
    put_word(3'd7, 8'hFF);
    put_word(ssd_pkg::FN_ABORT, 8'h00);
    put_word(ssd_pkg::FN_START, 8'h00);
    put_word(ssd_pkg::FN_ABORT, 8'h00);
    put_word(ssd_pkg::FN_RDERR, 8'h00);

    setup(1'b1, 6'd2, {240'd0, 8'h41, 8'h05}, {62'd0, 1'b1, 1'b0, 58'd0, 1'b1, 5'd0});
    put_word(ssd_pkg::FN_START, 8'h00);
    put_word(ssd_pkg::FN_BYTE, 8'h55);
    send_frame(1'b1);
    send_frame(1'b0);
    send_frame(1'b0);
    put_word(ssd_pkg::FN_START, 8'h00);
    put_word(ssd_pkg::FN_POP, 8'h00);
    put_word(ssd_pkg::FN_POP, 8'h00);
    put_word(ssd_pkg::FN_RDERR, 8'h00);
    put_word(ssd_pkg::FN_ABORT, 8'h00);

    for (int p = 0; p < 10; p++) begin
      for (int w = 0; w < 8; w++) rnd_ids[w*32 +: 32] = $urandom;
      rnd_wide = {$urandom, $urandom, $urandom, $urandom};
      calm = (p == 4);
      case (p >> 1)
        0: setup(p[0], 6'd1, '0, '0);
        1: setup(p[0], 6'd32, rnd_ids, {128{1'b1}});
        2: setup(p[0], 6'd0, rnd_ids & {32{8'h7F}}, rnd_wide);
        3: setup(p[0], 6'd63, {256{1'b1}}, {128{1'b1}});
        default: setup(p[0], 6'($urandom_range(1, 8)), rnd_ids & {32{8'h7F}}, rnd_wide);
      endcase
      run_phase(p[0], 75);
    end
    calm = 1'b0;

    settle();
    repeat (5) @(negedge clk);
    if (fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
